[src/assert_macros.svh]
// Assertion macros used by the RTL of the noise canceller.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/anc_pkg.sv]
// Package of the noise canceller: payload types, controller codes and
// fixed-point helpers. It depends on nothing else.
`timescale 1ns / 1ps

package anc_pkg;

    localparam int ANC_TAPS     = 128;
    localparam int ANC_SECTIONS = 5;
    localparam logic [15:0] STEP_RESET = 16'd1407;

    // Widest tap index and section index that the command struct carries.
    localparam int TAP_W = 9;
    localparam int SEC_W = 3;

    typedef struct packed {
        logic              opcode;
        logic [4:0]        coef_index;
        logic signed [15:0] coef_value;
        logic signed [15:0] ref_sample;
        logic signed [15:0] sig_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] error_out;
        logic signed [15:0] mix_out;
    } out_item_t;

    localparam logic OPC_SAMPLE = 1'b0;
    localparam logic OPC_COEF   = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_BQ, S_MIX, S_PRED, S_PDRAIN,
        S_ERR, S_SE, S_UPD, S_UDRAIN, S_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_COEF, OP_LOAD, OP_BQ, OP_MIX,
        OP_PRED, OP_ERR, OP_SE, OP_UPD, OP_OUT
    } dp_op_t;

    // Steps of one biquad section on the shared multiplier.
    typedef enum logic [3:0] {
        BQ_MUL_A1, BQ_MUL_A2, BQ_SUB_A2, BQ_WN, BQ_MUL_B0,
        BQ_MUL_B1, BQ_MUL_B2, BQ_ADD_B2, BQ_Y
    } bq_step_t;

    typedef struct packed {
        dp_op_t             op;
        logic [TAP_W-1:0]   tap;
        logic [SEC_W-1:0]   sec;
        bq_step_t           bq;
    } dp_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_status_t;

    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int unsigned s);
        logic signed [63:0] bias;
        bias = 64'sd1 <<< (s - 1);
        return (v + bias) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        if (v > 32'sd32767) begin
            return 16'sh7fff;
        end
        if (v < -32'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

[src/adaptive_noise_canceller_lms_unit.sv]
// A coefficient write is taken in the idle state and leaves the block idle; a sample
// frame keeps input requests stalled until its result is in the output register.
// Frames are taken one at a time: the shared multiplier runs the biquad steps and
// two sweeps over the tap memories, and no new frame is taken before one is through.
// Reset: asynchronous, active low; a clearing pass over all taps then zeroes
// the weight and history memories while input requests are stalled.
`timescale 1ns / 1ps

module adaptive_noise_canceller_lms_unit
    import anc_pkg::*;
#(
    parameter int TAPS     = ANC_TAPS,
    parameter int SECTIONS = ANC_SECTIONS
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input requests: sample frames and coefficient writes.
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    // Result requests: one per sample frame.
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    // Step size register write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    // The controller sequences each frame: nine steps per biquad section on
    // the shared multiplier, a prediction sweep over all taps, the error,
    // the step-times-error product and an update sweep over all taps. The
    // datapath owns the data registers, the memories and the output register, so a
    // finished result can wait there while the next request is accepted.
    dp_cmd_t    cmd;
    dp_status_t status;

    // The step size register can be written in any cycle.
    assign cfg_ready = 1'b1;

    anc_ctrl #(
        .TAPS     (TAPS),
        .SECTIONS (SECTIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_opcode (in_data.opcode),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    anc_dp #(
        .TAPS     (TAPS),
        .SECTIONS (SECTIONS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[src/anc_ctrl.sv]
// Controller of the noise canceller: the state machine and its counters.
// Depends on anc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module anc_ctrl
    import anc_pkg::*;
#(
    parameter int TAPS     = ANC_TAPS,
    parameter int SECTIONS = ANC_SECTIONS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_opcode,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam int AW = $clog2(TAPS);
    localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);
    localparam logic [SW-1:0] LAST_SEC = SW'(SECTIONS - 1);
    localparam logic [AW-1:0] DRAIN_LAST = AW'(1);

    state_t        state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] sec_reg, sec_next;
    bq_step_t      bq_reg, bq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            sec_reg   <= '0;
            bq_reg    <= BQ_MUL_A1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sec_reg   <= sec_next;
            bq_reg    <= bq_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sec_next   = sec_reg;
        bq_next    = bq_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_TAP)
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
            end
            S_IDLE:
            begin
                if (in_valid && (in_opcode == OPC_SAMPLE))
                begin
                    state_next = S_BQ;
                    sec_next   = '0;
                    bq_next    = BQ_MUL_A1;
                end
            end
            S_BQ:
            begin
                if (bq_reg == BQ_Y)
                begin
                    bq_next = BQ_MUL_A1;
                    if (sec_reg == LAST_SEC)
                    begin
                        state_next = S_MIX;
                    end
                    else
                    begin
                        sec_next = sec_reg + 1'b1;
                    end
                end
                else
                begin
                    bq_next = bq_step_t'(bq_reg + 4'd1);
                end
            end
            S_MIX:
            begin
                state_next = S_PRED;
                cnt_next   = '0;
            end
            S_PRED:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_TAP)
                begin
                    state_next = S_PDRAIN;
                    cnt_next   = '0;
                end
            end
            S_PDRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DRAIN_LAST)
                begin
                    state_next = S_ERR;
                    cnt_next   = '0;
                end
            end
            S_ERR:
            begin
                state_next = S_SE;
            end
            S_SE:
            begin
                state_next = S_UPD;
                cnt_next   = '0;
            end
            S_UPD:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_TAP)
                begin
                    state_next = S_UDRAIN;
                    cnt_next   = '0;
                end
            end
            S_UDRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DRAIN_LAST)
                begin
                    state_next = S_OUT;
                    cnt_next   = '0;
                end
            end
            S_OUT:
            begin
                if (!status.out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op  = OP_NONE;
        cmd.tap = TAP_W'(cnt_reg);
        cmd.sec = SEC_W'(sec_reg);
        cmd.bq  = bq_reg;
        case (state_reg)
            S_CLEAR:  cmd.op = OP_CLEAR;
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = (in_opcode == OPC_COEF) ? OP_COEF : OP_LOAD;
                end
            end
            S_BQ:     cmd.op = OP_BQ;
            S_MIX:    cmd.op = OP_MIX;
            S_PRED:   cmd.op = OP_PRED;
            S_ERR:    cmd.op = OP_ERR;
            S_SE:     cmd.op = OP_SE;
            S_UPD:    cmd.op = OP_UPD;
            S_OUT:    cmd.op = status.out_full ? OP_NONE : OP_OUT;
            default:  cmd.op = OP_NONE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    `ASSERT_NEXT(a_clear_once, state_reg != S_CLEAR, state_reg != S_CLEAR)
    `ASSERT_NEXT(a_out_waits, (state_reg == S_OUT) && status.out_full, state_reg == S_OUT)
    `ASSERT_NEXT(a_coef_one_cycle, (state_reg == S_IDLE) && in_valid && (in_opcode == OPC_COEF),
                 state_reg == S_IDLE)

endmodule

[src/anc_dp.sv]
// Datapath of the noise canceller: biquad registers, tap memories,
// shared multiplier, accumulator and output register. Depends on anc_pkg.
`timescale 1ns / 1ps

module anc_dp
    import anc_pkg::*;
#(
    parameter int TAPS     = ANC_TAPS,
    parameter int SECTIONS = ANC_SECTIONS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    input  in_item_t   in_data,
    input  logic       cfg_valid,
    input  logic [15:0] cfg_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data
);

    localparam int AW = $clog2(TAPS);
    localparam int NC = 5 * SECTIONS;
    localparam int CW = $clog2(NC);
    localparam int ND = 2 * SECTIONS;
    localparam int DW = $clog2(ND);
    localparam logic [AW:0] TAPS_W = (AW + 1)'(TAPS);
    localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);

    logic [15:0]        step_reg;
    logic signed [15:0] coef_reg [NC];
    logic signed [31:0] d_reg [ND];
    logic signed [31:0] x_reg;
    logic signed [15:0] sig_reg;
    logic signed [31:0] wn_reg;
    logic signed [31:0] mix_reg;
    logic signed [31:0] err_reg;
    logic signed [48:0] se_reg;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg;
    logic [AW-1:0]      hp_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    // Tap memories and the sweep pipeline.
    logic [31:0]        wmem [TAPS];
    logic [15:0]        hmem [TAPS];
    logic [31:0]        w_rd_reg;
    logic signed [15:0] h_rd_reg;
    logic               s1_valid_reg, s1_upd_reg, s2_valid_reg, s2_upd_reg;
    logic [AW-1:0]      s1_idx_reg, s2_idx_reg;
    logic signed [31:0] s2_w_reg;

    logic [AW-1:0] tap;
    logic [AW:0]   hsum;
    logic [AW-1:0] haddr;
    logic          sweep;
    logic          w_we, h_we;
    logic [AW-1:0] w_wa, h_wa;
    logic [31:0]   w_wd;
    logic [15:0]   h_wd;
    logic [AW-1:0] hp_dec;

    logic [SEC_W-1:0]   sec;
    logic [4:0]         cbase;
    logic [4:0]         cidx_w;
    logic [CW-1:0]      cidx;
    logic [3:0]         dbase_w;
    logic [DW-1:0]      di0, di1;
    logic signed [31:0] w0, w1;
    logic signed [48:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [64:0] mul_p;
    logic signed [31:0] upd_w;

    assign tap    = cmd.tap[AW-1:0];
    assign hsum   = {1'b0, hp_reg} + {1'b0, tap};
    assign haddr  = (hsum >= TAPS_W) ? AW'(hsum - TAPS_W) : hsum[AW-1:0];
    assign sweep  = (cmd.op == OP_PRED) || (cmd.op == OP_UPD);
    assign hp_dec = (hp_reg == '0) ? LAST_TAP : hp_reg - 1'b1;

    // Biquad operand selection for the current section.
    assign sec     = cmd.sec;
    assign cbase   = 5'(sec) * 5'd5;
    assign dbase_w = 4'(sec) * 4'd2;
    assign di0     = dbase_w[DW-1:0];
    assign di1     = DW'(dbase_w + 4'd1);
    assign w0      = d_reg[di0];
    assign w1      = d_reg[di1];
    assign cidx    = cidx_w[CW-1:0];

    always_comb
    begin
        cidx_w = cbase + 5'd3;
        mul_a  = 49'(w0);
        case (cmd.bq)
            BQ_MUL_A1:
            begin
                cidx_w = cbase + 5'd3;
                mul_a  = 49'(w0);
            end
            BQ_MUL_A2:
            begin
                cidx_w = cbase + 5'd4;
                mul_a  = 49'(w1);
            end
            BQ_MUL_B0:
            begin
                cidx_w = cbase;
                mul_a  = 49'(wn_reg);
            end
            BQ_MUL_B1:
            begin
                cidx_w = cbase + 5'd1;
                mul_a  = 49'(w0);
            end
            BQ_MUL_B2:
            begin
                cidx_w = cbase + 5'd2;
                mul_a  = 49'(w1);
            end
            default:
            begin
                cidx_w = cbase + 5'd3;
                mul_a  = 49'(w0);
            end
        endcase
        mul_b = coef_reg[cidx];
        // The sweep pipeline owns the multiplier while it holds a tap.
        if (s1_valid_reg)
        begin
            mul_a = s1_upd_reg ? se_reg : 49'(signed'(w_rd_reg));
            mul_b = h_rd_reg;
        end
    end

    assign mul_p = mul_a * mul_b;
    assign upd_w = sat32(64'(s2_w_reg) + round_shift(prod_reg, 16));

    // Memory write ports: clearing pass, new reference sample, weight update.
    always_comb
    begin
        w_we = 1'b0;
        w_wa = tap;
        w_wd = '0;
        h_we = 1'b0;
        h_wa = tap;
        h_wd = '0;
        if (cmd.op == OP_CLEAR)
        begin
            w_we = 1'b1;
            h_we = 1'b1;
        end
        if (cmd.op == OP_LOAD)
        begin
            h_we = 1'b1;
            h_wa = hp_dec;
            h_wd = in_data.ref_sample;
        end
        if (s2_valid_reg && s2_upd_reg)
        begin
            w_we = 1'b1;
            w_wa = s2_idx_reg;
            w_wd = upd_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wmem[w_wa] <= w_wd;
        end
        if (sweep)
        begin
            w_rd_reg <= wmem[tap];
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            hmem[h_wa] <= h_wd;
        end
        if (sweep)
        begin
            h_rd_reg <= hmem[haddr];
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (s2_valid_reg && !s2_upd_reg)
        begin
            acc_next = acc_reg + prod_reg;
        end
        if (cmd.op == OP_BQ)
        begin
            case (cmd.bq)
                BQ_MUL_A1:             acc_next = 64'(x_reg) <<< 14;
                BQ_MUL_A2, BQ_SUB_A2:  acc_next = acc_reg - prod_reg;
                BQ_MUL_B1:             acc_next = prod_reg;
                BQ_MUL_B2, BQ_ADD_B2:  acc_next = acc_reg + prod_reg;
                default:               acc_next = acc_reg;
            endcase
        end
        if (cmd.op == OP_MIX)
        begin
            acc_next = '0;
        end
    end

    // Control flags and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_RESET;
            hp_reg        <= '0;
            out_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            for (int i = 0; i < NC; i++)
            begin
                coef_reg[i] <= '0;
            end
            for (int i = 0; i < ND; i++)
            begin
                d_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                step_reg <= cfg_data;
            end
            s1_valid_reg <= sweep;
            s2_valid_reg <= s1_valid_reg;
            if ((cmd.op == OP_COEF) && (in_data.coef_index < 5'(NC)))
            begin
                coef_reg[in_data.coef_index[CW-1:0]] <= in_data.coef_value;
            end
            if (cmd.op == OP_LOAD)
            begin
                hp_reg <= hp_dec;
            end
            if ((cmd.op == OP_BQ) && (cmd.bq == BQ_Y))
            begin
                d_reg[di1] <= w0;
                d_reg[di0] <= wn_reg;
            end
            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        prod_reg   <= mul_p[63:0];
        s1_upd_reg <= (cmd.op == OP_UPD);
        s1_idx_reg <= tap;
        s2_upd_reg <= s1_upd_reg;
        s2_idx_reg <= s1_idx_reg;
        s2_w_reg   <= w_rd_reg;
        if (cmd.op == OP_LOAD)
        begin
            x_reg   <= 32'(in_data.ref_sample);
            sig_reg <= in_data.sig_sample;
        end
        if (cmd.op == OP_BQ)
        begin
            if (cmd.bq == BQ_WN)
            begin
                wn_reg <= sat32(round_shift(acc_reg, 14));
            end
            if (cmd.bq == BQ_Y)
            begin
                x_reg <= sat32(round_shift(acc_reg, 14));
            end
        end
        if (cmd.op == OP_MIX)
        begin
            mix_reg <= sat32(64'(x_reg) + 64'(sig_reg));
        end
        if (cmd.op == OP_ERR)
        begin
            err_reg <= sat32(64'(mix_reg) - 64'(sat32(round_shift(acc_reg, 30))));
        end
        if (cmd.op == OP_SE)
        begin
            se_reg <= 49'(signed'({1'b0, step_reg}) * err_reg);
        end
        if (cmd.op == OP_OUT)
        begin
            out_data_reg.error_out <= sat16(err_reg);
            out_data_reg.mix_out   <= sat16(mix_reg);
        end
    end

    assign status.out_full = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

[test/adaptive_noise_canceller_lms_unit_tb.sv]
// Self-checking testbench of the LMS noise canceller with its biquad noise path.
// It drives sample frames, coefficient writes and step size writes, predicts every
// result bit for bit, and depends on anc_pkg and adaptive_noise_canceller_lms_unit.
`timescale 1ns / 1ps

module adaptive_noise_canceller_lms_unit_tb;
    import anc_pkg::*;

    localparam int NTAPS = ANC_TAPS;
    localparam int NSEC  = ANC_SECTIONS;
    // FRAME_CYCLES is the length of one frame; the drain wait allows for more.
    localparam int FRAME_CYCLES = 2 * NTAPS + 9 * NSEC + 9;
    localparam int DRAIN_CYCLES = 4 * FRAME_CYCLES;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    adaptive_noise_canceller_lms_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the block's state, kept by the predictor.
    logic [15:0]        pr_step;
    logic signed [15:0] pr_coef [5*NSEC];
    logic signed [31:0] pr_delay [2*NSEC];
    logic signed [31:0] pr_weight [NTAPS];
    logic signed [15:0] pr_hist [NTAPS];

    out_item_t expected_results [$];
    int        error_count;
    longint    cycle_count;

    // Idle percentages for each side, and the long receiver hold-off.
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_output;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Rounding to nearest, ties toward plus infinity: an arithmetic shift floors.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int s);
        logic signed [63:0] biased;
        biased = v + (64'sd1 <<< (s - 1));
        return biased >>> s;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] clip16(input logic signed [31:0] v);
        if (v > 32'sd32767)
        begin
            return 16'sh7fff;
        end
        else if (v < -32'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    task automatic clear_shadow();
        pr_step = STEP_RESET;
        foreach (pr_coef[i]) pr_coef[i] = '0;
        foreach (pr_delay[i]) pr_delay[i] = '0;
        foreach (pr_weight[i]) pr_weight[i] = '0;
        foreach (pr_hist[i]) pr_hist[i] = '0;
    endtask

    // Works out the cleaned signal and mixture of one accepted request and
    // updates the shadow state the way the block does.
    task automatic predict_canceller(input in_item_t item);
        logic signed [63:0] acc;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] w0;
        logic signed [31:0] w1;
        logic signed [31:0] wn;
        logic signed [31:0] mix;
        logic signed [31:0] err;
        logic signed [63:0] d;
        out_item_t res;
        if (item.opcode == OPC_COEF)
        begin
            // Slots beyond the cascade are dropped.
            if (item.coef_index < 5 * NSEC)
            begin
                pr_coef[item.coef_index] = item.coef_value;
            end
            return;
        end
        x = item.ref_sample;
        y = '0;
        for (int s = 0; s < NSEC; s++)
        begin
            w0 = pr_delay[2*s];
            w1 = pr_delay[2*s+1];
            acc = 64'(x) * 64'sd16384 - 64'(pr_coef[5*s+3]) * 64'(w0)
                  - 64'(pr_coef[5*s+4]) * 64'(w1);
            wn = clip32(rnd_shift(acc, 14));
            acc = 64'(pr_coef[5*s]) * 64'(wn) + 64'(pr_coef[5*s+1]) * 64'(w0)
                  + 64'(pr_coef[5*s+2]) * 64'(w1);
            y = clip32(rnd_shift(acc, 14));
            pr_delay[2*s+1] = w0;
            pr_delay[2*s]   = wn;
            x = y;
        end
        mix = clip32(64'(y) + 64'(item.sig_sample));
        // The newest reference becomes tap 0 before the prediction.
        for (int k = NTAPS - 1; k > 0; k--)
        begin
            pr_hist[k] = pr_hist[k-1];
        end
        pr_hist[0] = item.ref_sample;
        acc = '0;
        for (int k = 0; k < NTAPS; k++)
        begin
            acc += 64'(pr_weight[k]) * 64'(pr_hist[k]);
        end
        err = clip32(64'(mix) - 64'(clip32(rnd_shift(acc, 30))));
        for (int k = 0; k < NTAPS; k++)
        begin
            d = 64'($signed({1'b0, pr_step})) * 64'(err) * 64'(pr_hist[k]);
            pr_weight[k] = clip32(64'(pr_weight[k]) + rnd_shift(d, 16));
        end
        res.error_out = clip16(err);
        res.mix_out   = clip16(mix);
        expected_results.push_back(res);
    endtask

    // Offers one request and holds it until the block takes it. Valid stays
    // high into the next request unless the sender idles first.
    task automatic send_request(input in_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_canceller(item);
        @(negedge clk);
    endtask

    // Waits until every result is back and the block has gone quiet, then writes
    // the step size register.
    task automatic write_step(input logic [15:0] value);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (FRAME_CYCLES + 20) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        pr_step = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t frame(input logic signed [15:0] r,
                                       input logic signed [15:0] s);
        in_item_t it;
        it = '0;
        it.opcode = OPC_SAMPLE;
        it.ref_sample = r;
        it.sig_sample = s;
        it.coef_value = 16'($urandom);
        it.coef_index = 5'($urandom);
        return it;
    endfunction

    function automatic in_item_t coef_write(input logic [4:0] idx,
                                            input logic signed [15:0] v);
        in_item_t it;
        it = '0;
        it.opcode = OPC_COEF;
        it.coef_index = idx;
        it.coef_value = v;
        it.ref_sample = 16'($urandom);
        it.sig_sample = 16'($urandom);
        return it;
    endfunction

    // A random stable-ish section: unity-ish feed forward, small feedback.
    task automatic load_random_cascade();
        for (int s = 0; s < NSEC; s++)
        begin
            send_request(coef_write(5'(5*s),   16'($urandom_range(8192, 24576))));
            send_request(coef_write(5'(5*s+1), 16'($signed($urandom_range(0, 16383)) - 8192)));
            send_request(coef_write(5'(5*s+2), 16'($signed($urandom_range(0, 8191)) - 4096)));
            send_request(coef_write(5'(5*s+3), 16'($signed($urandom_range(0, 8191)) - 4096)));
            send_request(coef_write(5'(5*s+4), 16'($signed($urandom_range(0, 4095)) - 2048)));
        end
    endtask

    function automatic in_item_t random_request();
        in_item_t it;
        int pick;
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            // Any slot, beyond-the-cascade ones included, with any value.
            it = coef_write(5'($urandom), 16'($urandom));
        end
        else if (pick < 15)
        begin
            // Full-scale extremes drive every saturation path.
            it = frame($urandom_range(1) ? 16'sh7fff : 16'sh8000,
                       $urandom_range(1) ? 16'sh7fff : 16'sh8000);
        end
        else
        begin
            it = frame(16'($urandom), 16'($urandom));
        end
        return it;
    endfunction

    // Directed table. Rows with a typed-in result are read off at a glance: with
    // all coefficients zero right after reset the noise path gives nothing and
    // the weights are zero, so both outputs equal the signal sample.
    typedef struct {
        in_item_t  item;
        bit        has_result;
        out_item_t result;
    } directed_row_t;

    directed_row_t directed_rows [$];

    task automatic add_row(input in_item_t it, input bit known,
                           input logic signed [15:0] e, input logic signed [15:0] m);
        directed_row_t r;
        r.item = it;
        r.has_result = known;
        r.result.error_out = e;
        r.result.mix_out = m;
        directed_rows.push_back(r);
    endtask

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result error=%0d mix=%0d", $time,
                         out_data.error_out, out_data.mix_out);
                error_count++;
            end
            else
            begin
                out_item_t want;
                want = expected_results.pop_front();
                if (out_data.error_out !== want.error_out)
                begin
                    $display("%0t: error_out expected %0d actual %0d", $time,
                             want.error_out, out_data.error_out);
                    error_count++;
                end
                if (out_data.mix_out !== want.mix_out)
                begin
                    $display("%0t: mix_out expected %0d actual %0d", $time,
                             want.mix_out, out_data.mix_out);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall, changed at the falling edge. A long hold-off, when asked
    // for, is counted here so that the sender keeps offering and the block fills.
    initial
    begin
        int hold_left;
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_output && hold_left == 0)
            begin
                hold_left = 3 * FRAME_CYCLES;
                hold_output = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int random_items;
        error_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_output   = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        clear_shadow();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: zero cascade first, extremes of the samples.
        add_row(frame(16'sh0000, 16'sh0000), 1, 16'sh0000, 16'sh0000);
        add_row(frame(16'sh0000, 16'sh7fff), 1, 16'sh7fff, 16'sh7fff);
        add_row(frame(16'sh0000, 16'sh8000), 1, 16'sh8000, 16'sh8000);
        add_row(frame(16'sh7fff, 16'sh7fff), 0, '0, '0);
        add_row(frame(16'sh8000, 16'sh8000), 0, '0, '0);
        // Coefficient writes: pass-through first section, extremes, and two slots
        // beyond the cascade that must be ignored.
        add_row(coef_write(5'd0, 16'sh4000), 0, '0, '0);
        add_row(coef_write(5'd5, 16'sh7fff), 0, '0, '0);
        add_row(coef_write(5'd10, 16'sh8000), 0, '0, '0);
        add_row(coef_write(5'd3, 16'sh8000), 0, '0, '0);
        add_row(coef_write(5'd4, 16'sh7fff), 0, '0, '0);
        add_row(coef_write(5'd25, 16'sh4000), 0, '0, '0);
        add_row(coef_write(5'd31, 16'shffff), 0, '0, '0);
        add_row(frame(16'sh7fff, 16'sh0000), 0, '0, '0);
        add_row(frame(16'sh8000, 16'sh7fff), 0, '0, '0);
        add_row(frame(16'sh1234, 16'shedcb), 0, '0, '0);
        add_row(frame(16'sh7fff, 16'sh8000), 0, '0, '0);
        add_row(frame(16'shffff, 16'sh0001), 0, '0, '0);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].item);
            if (directed_rows[i].has_result)
            begin
                // The typed-in value must agree with the predictor's own one.
                if (expected_results[$] !== directed_rows[i].result)
                begin
                    $display("%0t: directed row %0d expected %h predicted %h", $time, i,
                             directed_rows[i].result, expected_results[$]);
                    error_count++;
                end
            end
        end

        // Extremes of the step size, then random settings with random cascades.
        write_step(16'd0);
        for (int i = 0; i < 8; i++) send_request(random_request());
        write_step(16'hffff);
        for (int i = 0; i < 8; i++) send_request(random_request());

        random_items = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 76 : 0;
            recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 17 : 0;
            write_step((phase == 2) ? STEP_RESET : 16'($urandom_range(0, 4000)));
            load_random_cascade();
            if (phase == 0)
            begin
                hold_output = 1'b1;
            end
            for (int i = 0; i < 340; i++)
            begin
                send_request(random_request());
                random_items++;
            end
        end

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
